// File: design/lrsc_pkg.sv
// lrsc_pkg: shared types and constants for the lidar range step classifier
// used by lrsc_classify, lrsc_out_fifo and the top level lidar_range_step_classifier
package lrsc_pkg;

    localparam int WINDOW_SIDE = 3;
    localparam int WIN_DEPTH   = 2 * WINDOW_SIDE;
    localparam int FIFO_DEPTH  = 3;
    localparam int RANGE_W     = 16;
    localparam int COL_W       = 12;
    localparam int CRIT_W      = 12;
    localparam logic [CRIT_W-1:0] CRIT_MAX = 12'd4095;

    // register reset values
    localparam logic [RANGE_W-1:0] OBSTACLE_RST = 16'd500;
    localparam logic [RANGE_W-1:0] CRITICAL_RST = 16'd500;
    localparam logic [RANGE_W-1:0] INV_BELOW_RST = 16'd2;
    localparam logic [RANGE_W-1:0] FAR_LIMIT_RST = 16'd29000;
    localparam logic [RANGE_W-1:0] INV_FILL_RST = 16'd30000;

    typedef enum logic [2:0] {
        CFG_OBSTACLE  = 3'd0,
        CFG_CRITICAL  = 3'd1,
        CFG_INV_BELOW = 3'd2,
        CFG_FAR_LIMIT = 3'd3,
        CFG_INV_FILL  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLASS_NONE    = 2'd0,
        CLASS_RISING  = 2'd1,
        CLASS_CRIT    = 2'd2,
        CLASS_FALLING = 2'd3
    } class_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_ALARM   = 2'd1,
        ACT_SILENCE = 2'd2
    } action_t;

    typedef enum logic {
        KIND_SAMPLE  = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [RANGE_W-1:0] obstacle_thresh_mm;
        logic [RANGE_W-1:0] critical_thresh_mm;
        logic [RANGE_W-1:0] invalid_below_mm;
        logic [RANGE_W-1:0] far_limit_mm;
        logic [RANGE_W-1:0] invalid_fill_mm;
    } cfg_t;

    typedef struct packed {
        kind_t             item_kind;
        logic [COL_W-1:0]  column;
        class_t            color_class;
        logic [CRIT_W-1:0] critical_seen;
        action_t           alarm_action;
        logic              run_last;
    } result_t;

    // up to two results written into the output queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: design/lrsc_classify.sv
// lrsc_classify: input register, six-sample window and per-sample classification
// depends on lrsc_pkg; feeds lrsc_out_fifo
module lrsc_classify
    import lrsc_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [RANGE_W-1:0] range_mm,
    input  logic               scan_last,
    input  cfg_t               cfg,
    input  logic [1:0]         fifo_count,
    output push_t              push
);

    localparam int CW = $clog2(MAX_COLUMNS);

    logic               in_valid_reg;
    logic [RANGE_W-1:0] in_range_reg;
    logic               in_last_reg;

    logic [RANGE_W-1:0] win_reg [WIN_DEPTH];
    logic [2:0]         fill_reg;
    class_t             class_reg;
    logic [CRIT_W-1:0]  crit_cnt_reg;
    logic [CW-1:0]      col_cnt_reg;
    logic               latch_reg;

    logic [RANGE_W-1:0] nw [WIN_DEPTH];
    logic               classify_en;
    logic [1:0]         need;
    logic [1:0]         space;
    logic               proc;

    logic [RANGE_W-1:0] succ_med;
    logic [RANGE_W-1:0] prev_med;
    logic [RANGE_W-1:0] r_raw;
    logic [RANGE_W-1:0] r_eff;
    logic [RANGE_W-1:0] diff_base;
    logic               invalid;
    logic signed [17:0] diff;
    logic signed [17:0] th;
    logic signed [17:0] neg_th;
    class_t             cls_new;
    logic [CRIT_W-1:0]  crit_after;
    logic [CW-1:0]      col_idx;
    logic [CW+11:0]     col_wide;
    action_t            act;
    logic               latch_next;
    result_t            res_cls;
    result_t            res_sum;

    function automatic logic [RANGE_W-1:0] med3(
        input logic [RANGE_W-1:0] a,
        input logic [RANGE_W-1:0] b,
        input logic [RANGE_W-1:0] c
    );
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
        begin
            return lo;
        end
        else if (c >= hi)
        begin
            return hi;
        end
        return c;
    endfunction

    // window as it stands once the held sample is shifted in
    always_comb
    begin
        nw[0] = in_range_reg;
        for (int i = 1; i < WIN_DEPTH; i++)
        begin
            nw[i] = win_reg[i-1];
        end
    end

    assign classify_en = (fill_reg >= 3'(WIN_DEPTH - 1));
    assign need        = {1'b0, classify_en} + {1'b0, in_last_reg};
    assign space       = 2'(FIFO_DEPTH) - fifo_count;
    assign proc        = in_valid_reg && (need <= space);
    assign s_tready    = !in_valid_reg || proc;

    assign r_raw     = nw[WINDOW_SIDE];
    assign succ_med  = med3(nw[0], nw[1], nw[2]);
    assign prev_med  = med3(r_raw, nw[WINDOW_SIDE+1], nw[WINDOW_SIDE+2]);
    assign invalid   = (r_raw < cfg.invalid_below_mm);
    assign r_eff     = invalid ? cfg.invalid_fill_mm : r_raw;
    assign diff_base = invalid ? cfg.invalid_fill_mm : prev_med;
    assign diff      = $signed({2'b00, diff_base}) - $signed({2'b00, succ_med});
    assign th        = $signed({2'b00, cfg.obstacle_thresh_mm});
    assign neg_th    = -th;

    // rules in priority order; an invalid return is forced to falling first
    always_comb
    begin
        cls_new    = invalid ? CLASS_FALLING : class_reg;
        crit_after = crit_cnt_reg;
        if (r_eff > cfg.far_limit_mm)
        begin
            cls_new = CLASS_FALLING;
        end
        else if (r_eff < cfg.critical_thresh_mm)
        begin
            cls_new = CLASS_CRIT;
            if (classify_en && (crit_cnt_reg < CRIT_MAX))
            begin
                crit_after = crit_cnt_reg + 1'b1;
            end
        end
        else if (diff > th)
        begin
            cls_new = CLASS_RISING;
        end
        else if (diff < neg_th)
        begin
            cls_new = CLASS_FALLING;
        end
    end

    always_comb
    begin
        act        = ACT_NONE;
        latch_next = latch_reg;
        if (crit_after != '0)
        begin
            act        = ACT_ALARM;
            latch_next = 1'b1;
        end
        else if (latch_reg)
        begin
            act        = ACT_SILENCE;
            latch_next = 1'b0;
        end
    end

    assign col_idx  = (col_cnt_reg >= CW'(WINDOW_SIDE)) ? col_cnt_reg - CW'(WINDOW_SIDE) : '0;
    assign col_wide = {12'd0, col_idx};

    always_comb
    begin
        res_cls.item_kind     = KIND_SAMPLE;
        res_cls.column        = col_wide[COL_W-1:0];
        res_cls.color_class   = cls_new;
        res_cls.critical_seen = crit_after;
        res_cls.alarm_action  = ACT_NONE;
        res_cls.run_last      = !in_last_reg;

        res_sum.item_kind     = KIND_SUMMARY;
        res_sum.column        = '0;
        res_sum.color_class   = CLASS_NONE;
        res_sum.critical_seen = crit_after;
        res_sum.alarm_action  = act;
        res_sum.run_last      = 1'b1;

        push.cnt    = proc ? need : 2'd0;
        push.first  = classify_en ? res_cls : res_sum;
        push.second = res_sum;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_range_reg <= range_mm;
            in_last_reg  <= scan_last;
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
            fill_reg     <= '0;
            class_reg    <= CLASS_NONE;
            crit_cnt_reg <= '0;
            col_cnt_reg  <= '0;
            latch_reg    <= 1'b0;
        end
        else if (proc)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= nw[i];
            end
            if (in_last_reg)
            begin
                fill_reg     <= '0;
                class_reg    <= CLASS_NONE;
                crit_cnt_reg <= '0;
                col_cnt_reg  <= '0;
                latch_reg    <= latch_next;
            end
            else
            begin
                if (fill_reg < 3'(WIN_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (classify_en)
                begin
                    class_reg <= cls_new;
                end
                crit_cnt_reg <= crit_after;
                if (col_cnt_reg < CW'(MAX_COLUMNS - 1))
                begin
                    col_cnt_reg <= col_cnt_reg + 1'b1;
                end
            end
        end
    end

    a_scan_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_last_reg |=> fill_reg == '0 && crit_cnt_reg == '0 && class_reg == CLASS_NONE)
        else $error("scan state not cleared after scan end");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 3'(WIN_DEPTH))
        else $error("window fill beyond depth");

endmodule

// File: design/lrsc_out_fifo.sv
// lrsc_out_fifo: three-entry result queue, up to two writes and one read a cycle
// depends on lrsc_pkg; fed by lrsc_classify
module lrsc_out_fifo
    import lrsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       m_tvalid,
    input  logic       m_tready,
    output result_t    head,
    output logic [1:0] count
);

    result_t    mem_reg [FIFO_DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] wr_ptr_inc;
    logic       pop;
    logic [2:0] count_next;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'(FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign m_tvalid   = (count_reg != 2'd0);
    assign pop        = m_tvalid && m_tready;
    assign head       = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);
    assign count_next = {1'b0, count_reg} + {1'b0, push.cnt} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FIFO_DEPTH; i++)
        begin
            if ((push.cnt != 2'd0) && (2'(i) == wr_ptr_reg))
            begin
                mem_reg[i] <= push.first;
            end
            else if ((push.cnt == 2'd2) && (2'(i) == wr_ptr_inc))
            begin
                mem_reg[i] <= push.second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.cnt == 2'd1)
            begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            else if (push.cnt == 2'd2)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_inc);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next[1:0];
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, push.cnt} + {1'b0, count_reg}) <= 3'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd1 && pop && push.cnt == 2'd0 |=> !m_tvalid)
        else $error("queue not empty after last entry read");

endmodule

// File: design/lidar_range_step_classifier.sv
// lidar_range_step_classifier: top level, configuration registers and stream packing
// depends on lrsc_pkg, lrsc_classify and lrsc_out_fifo
// a sample transfer is held in the input register until the result queue has room
//   for its results, which are then written into the queue and can transfer from there
// throughput: one sample per cycle while the result queue has room; the output side sets
//   the pace, and a scan-ending sample with a full window yields two results
// reset: rst_n clears the window, counters, class, critical latch and queue, and
//   loads the register defaults; no clearing pass is needed
module lidar_range_step_classifier
    import lrsc_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] range_mm
    input  logic        s_tlast,   // scan_last
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] column, [13:12] color_class,
                                   // [25:14] critical_seen, [27:26] alarm_action, rest zero
    output logic        m_tlast,   // run_last
    output logic        m_tuser,   // item_kind
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [15:0] cfg_data
);

    cfg_t       cfg_reg;
    push_t      push;
    result_t    head;
    logic [1:0] fifo_count;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.obstacle_thresh_mm <= OBSTACLE_RST;
            cfg_reg.critical_thresh_mm <= CRITICAL_RST;
            cfg_reg.invalid_below_mm   <= INV_BELOW_RST;
            cfg_reg.far_limit_mm       <= FAR_LIMIT_RST;
            cfg_reg.invalid_fill_mm    <= INV_FILL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_OBSTACLE:  cfg_reg.obstacle_thresh_mm <= cfg_data;
                CFG_CRITICAL:  cfg_reg.critical_thresh_mm <= cfg_data;
                CFG_INV_BELOW: cfg_reg.invalid_below_mm   <= cfg_data;
                CFG_FAR_LIMIT: cfg_reg.far_limit_mm       <= cfg_data;
                CFG_INV_FILL:  cfg_reg.invalid_fill_mm    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // window, median compare and scan bookkeeping
    lrsc_classify #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .range_mm   (s_tdata),
        .scan_last  (s_tlast),
        .cfg        (cfg_reg),
        .fifo_count (fifo_count),
        .push       (push)
    );

    // result queue decouples the output side from the sample side
    lrsc_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head),
        .count    (fifo_count)
    );

    // pack the head result onto the output stream
    assign m_tdata = {4'd0, head.alarm_action, head.critical_seen,
                      head.color_class, head.column};
    assign m_tlast = head.run_last;
    assign m_tuser = head.item_kind;

endmodule

// File: sim/tb_top.sv
// tb_top: stream-level check of lidar_range_step_classifier against a cycle-free predictor
// depends on lrsc_pkg and the lidar_range_step_classifier rtl, nothing else
`timescale 1ns / 1ps

module tb_top;
    import lrsc_pkg::*;

    localparam int MAX_COLUMNS     = 4096;
    localparam int DRAIN_LIMIT     = 4000;  // cycles allowed for results to come back
    localparam int SETTLE_CYCLES   = 6;     // input register plus result queue, with margin
    localparam int MAX_PRINTED     = 40;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int LONG_SCAN_ITEMS = 150;   // one long all-critical scan
    localparam int HOLD_OFF_CYCLES = 300;

    // register indexes the block does not decode
    localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CFG_SPARE_LAST  = 3'd7;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [15:0] range_mm
    logic        s_tlast  = 1'b0;   // scan_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [11:0] column, [13:12] color_class,
                                    // [25:14] critical_seen, [27:26] alarm_action
    logic        m_tlast;           // run_last
    logic        m_tuser;           // item_kind
    logic        cfg_we   = 1'b0;
    logic [2:0]  cfg_idx  = '0;
    logic [15:0] cfg_data = '0;

    lidar_range_step_classifier #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor copy of the block's registers and scan state
    // ------------------------------------------------------------------
    logic [15:0] obst_th   = OBSTACLE_RST;
    logic [15:0] crit_th   = CRITICAL_RST;
    logic [15:0] inv_below = INV_BELOW_RST;
    logic [15:0] far_lim   = FAR_LIMIT_RST;
    logic [15:0] inv_fill  = INV_FILL_RST;

    logic [15:0] range_window [WIN_DEPTH] = '{default: '0};
    int          window_seen = 0;
    class_t      held_class  = CLASS_NONE;
    logic [11:0] crit_tally  = '0;
    logic [11:0] walk_index  = '0;
    logic        crit_latch  = 1'b0;

    // classifier verdicts still owed by the block, oldest first
    result_t     predicted_verdicts [$];

    int          mismatch_count = 0;
    int          src_gap_pct    = 0;    // chance per transfer of a sender gap burst
    int          sink_stall_pct = 0;    // chance per cycle of a receiver stall burst
    int          hold_off_req   = 0;    // one long receiver hold-off, in cycles
    int          walk_level     = 1000; // plateau that random samples wander around

    // ------------------------------------------------------------------
    // clock, reset and overall time limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int median_of_three(int a, int b, int c);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) return lo;
        if (c >= hi) return hi;
        return c;
    endfunction

    // append one predicted result behind the ones already owed
    function automatic void owe_verdict(result_t v);
        predicted_verdicts.insert(predicted_verdicts.size(), v);
    endfunction

    // one accepted sample: shift the window, classify the middle entry once
    // the window is full, and close the scan on its last sample
    function automatic void classify_range(logic [15:0] rng, logic lst);
        logic [11:0] newest;
        logic [11:0] col;
        logic [15:0] r;
        int          succ;
        int          diff;
        int          th;
        result_t     v;
        action_t     act;
        newest = walk_index;
        for (int i = WIN_DEPTH - 1; i > 0; i--)
            range_window[i] = range_window[i - 1];
        range_window[0] = rng;
        if (window_seen < WIN_DEPTH) window_seen++;
        if (walk_index < MAX_COLUMNS - 1) walk_index++;

        if (window_seen >= WIN_DEPTH)
        begin
            // middle entry is the sample under test, the three newer ones its successors
            r    = range_window[WINDOW_SIDE];
            succ = median_of_three(range_window[0], range_window[1], range_window[2]);
            th   = int'(obst_th);
            col  = (newest >= WINDOW_SIDE) ? 12'(newest - WINDOW_SIDE) : '0;
            if (r < inv_below)
            begin
                // invalid return: forced far, and the fill value stands in for it
                held_class = CLASS_FALLING;
                r          = inv_fill;
                diff       = int'(r) - succ;
            end
            else
                diff = median_of_three(r, range_window[4], range_window[5]) - succ;

            if (r > far_lim)
                held_class = CLASS_FALLING;
            else if (r < crit_th)
            begin
                if (crit_tally < CRIT_MAX) crit_tally++;
                held_class = CLASS_CRIT;
            end
            else if (diff > th)
                held_class = CLASS_RISING;
            else if (diff < -th)
                held_class = CLASS_FALLING;
            // no rule hit: class carries over from the previous sample

            v.item_kind     = KIND_SAMPLE;
            v.column        = col;
            v.color_class   = held_class;
            v.critical_seen = crit_tally;
            v.alarm_action  = ACT_NONE;
            v.run_last      = !lst;
            owe_verdict(v);
        end

        if (lst)
        begin
            // alarm while anything critical was seen, silence once it clears
            if (crit_tally > 0)
            begin
                act        = ACT_ALARM;
                crit_latch = 1'b1;
            end
            else if (crit_latch)
            begin
                act        = ACT_SILENCE;
                crit_latch = 1'b0;
            end
            else
                act = ACT_NONE;
            v.item_kind     = KIND_SUMMARY;
            v.column        = '0;
            v.color_class   = CLASS_NONE;
            v.critical_seen = crit_tally;
            v.alarm_action  = act;
            v.run_last      = 1'b1;
            owe_verdict(v);
            window_seen = 0;
            held_class  = CLASS_NONE;
            crit_tally  = '0;
            walk_index  = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns mismatch, %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // outputs are sampled mid-cycle, where they hold the values the next rising
    // edge sees; m_tready is ours and only moves at rising edges
    always @(negedge clk)
    begin : verdict_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_verdicts.size() == 0)
                flag_mismatch("result transfer with nothing predicted", m_tdata, '0);
            else
            begin
                want = predicted_verdicts.pop_front();
                if (m_tuser !== want.item_kind)
                    flag_mismatch("item_kind", m_tuser, want.item_kind);
                if (m_tdata[11:0] !== want.column)
                    flag_mismatch("column", m_tdata[11:0], want.column);
                if (m_tdata[13:12] !== want.color_class)
                    flag_mismatch("color_class", m_tdata[13:12], want.color_class);
                if (m_tdata[25:14] !== want.critical_seen)
                    flag_mismatch("critical_seen", m_tdata[25:14], want.critical_seen);
                if (m_tdata[27:26] !== want.alarm_action)
                    flag_mismatch("alarm_action", m_tdata[27:26], want.alarm_action);
                if (m_tdata[31:28] !== 4'b0)
                    flag_mismatch("tdata padding", m_tdata[31:28], '0);
                if (m_tlast !== want.run_last)
                    flag_mismatch("run_last", m_tlast, want.run_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off_req > 0)
            begin
                n            = hold_off_req;
                hold_off_req = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // sender and configuration helpers, all entered at a rising edge
    // ------------------------------------------------------------------
    task automatic push_range_sample(logic [15:0] rng, logic lst);
        bit ready_seen;
        if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rng;
        s_tlast  <= lst;
        // tready is read mid-cycle so the transfer edge is known without a race
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        classify_range(rng, lst);
    endtask

    // drop valid and let everything owed drain out, then let the pipe settle
    task automatic wait_quiet();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (predicted_verdicts.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (predicted_verdicts.size() != 0)
            flag_mismatch("results still owed after drain", predicted_verdicts.size(), '0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_OBSTACLE:  obst_th   = value;
            CFG_CRITICAL:  crit_th   = value;
            CFG_INV_BELOW: inv_below = value;
            CFG_FAR_LIMIT: far_lim   = value;
            CFG_INV_FILL:  inv_fill  = value;
            default: ;    // undecoded index, nothing changes
        endcase
    endtask

    // only called with the block idle
    task automatic program_registers(logic [15:0] obst, logic [15:0] crit,
                                     logic [15:0] below, logic [15:0] far,
                                     logic [15:0] fill, bit with_spare);
        write_register(CFG_OBSTACLE, obst);
        write_register(CFG_CRITICAL, crit);
        write_register(CFG_INV_BELOW, below);
        write_register(CFG_FAR_LIMIT, far);
        write_register(CFG_INV_FILL, fill);
        if (with_spare)
            write_register(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                           16'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] clamp_range(int v);
        if (v < 0) return '0;
        if (v > 65535) return 16'hFFFF;
        return 16'(v);
    endfunction

    // random sample: mostly a noisy plateau with steps near the obstacle
    // threshold, sprinkled with values around every other threshold
    function automatic logic [15:0] next_range();
        int pick;
        int step;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 16'($urandom);
        if (pick < 18)
            return clamp_range(int'(inv_below) + $urandom_range(0, 4) - 3);
        if (pick < 26)
            return clamp_range(int'(crit_th) + $urandom_range(0, 6) - 3);
        if (pick < 32)
            return clamp_range(int'(far_lim) + $urandom_range(0, 6) - 3);
        if (pick < 44)
        begin
            step       = int'(obst_th) + $urandom_range(0, 4) - 2;
            walk_level = int'(clamp_range($urandom_range(0, 1) ? walk_level + step
                                                                : walk_level - step));
        end
        else if (pick < 50)
            walk_level = $urandom_range(0, 40000);
        return clamp_range(walk_level + $urandom_range(0, 20) - 10);
    endfunction

    task automatic program_random_registers();
        program_registers(
            $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000)),
            $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000)),
            $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 60)),
            $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(8000, 65535)),
            16'($urandom), $urandom_range(0, 1));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset defaults: a scan too short to classify, a scan through every rule
    // (invalid, far, critical, both steps, extremes), then a flat scan whose
    // class stays at none and whose summary silences the earlier alarm
    task automatic test_scan_shapes();
        logic [15:0] short_scan [3]  = '{16'd100, 16'hFFFF, 16'd0};
        logic [15:0] mixed_scan [14] = '{16'd1000, 16'd1000, 16'd1000, 16'd1000,
                                         16'd5000, 16'd5000, 16'd5000, 16'd0,
                                         16'd1000, 16'd2, 16'hFFFF, 16'd300,
                                         16'd1000, 16'd1000};
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        foreach (short_scan[i])
            push_range_sample(short_scan[i], i == 2);
        foreach (mixed_scan[i])
            push_range_sample(mixed_scan[i], i == 13);
        for (int i = 0; i < 7; i++)
            push_range_sample(16'd2000, i == 6);
        wait_quiet();
    endtask

    // all-zero and all-ones register settings, then back to the defaults
    task automatic test_register_extremes();
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 0)
                program_registers('0, '0, '0, '0, '0, 1'b1);
            else
                program_registers('1, '1, '1, '1, '1, 1'b1);
            for (int i = 0; i < 12; i++)
                case ($urandom_range(0, 2))
                    0: push_range_sample('0, i == 11);
                    1: push_range_sample('1, i == 11);
                    default: push_range_sample(16'($urandom), i == 11);
                endcase
            wait_quiet();
        end
        program_registers(OBSTACLE_RST, CRITICAL_RST, INV_BELOW_RST, FAR_LIMIT_RST,
                          INV_FILL_RST, 1'b0);
    endtask

    // one long scan with every sample critical, so the tally climbs on
    // every classified sample and the summary raises the alarm
    task automatic test_long_scan();
        program_registers(OBSTACLE_RST, '1, '0, '1, INV_FILL_RST, 1'b0);
        src_gap_pct    = 3;
        sink_stall_pct = 3;
        for (int i = 0; i < LONG_SCAN_ITEMS; i++)
            push_range_sample(16'($urandom_range(0, 65534)), i == LONG_SCAN_ITEMS - 1);
        wait_quiet();
        program_registers(OBSTACLE_RST, CRITICAL_RST, INV_BELOW_RST, FAR_LIMIT_RST,
                          INV_FILL_RST, 1'b0);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the result queue fills and the block stalls its input
    task automatic test_backpressure();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_off_req   = HOLD_OFF_CYCLES;
        for (int i = 0; i < 50; i++)
            push_range_sample(next_range(), i == 49);
        wait_quiet();
    endtask

    // well-formed scans with random content and lengths, a few too short to
    // classify; registers change every few hundred samples; the last fifth
    // runs with no idling at all
    task automatic test_random_scans(int n_items);
        int sent;
        int len;
        int next_cfg_at;
        sent        = 0;
        next_cfg_at = 250;
        while (sent < n_items)
        begin
            if (sent >= next_cfg_at)
            begin
                wait_quiet();
                program_random_registers();
                next_cfg_at += 250;
            end
            if (sent >= n_items * 4 / 5)
            begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            else
            begin
                src_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : $urandom_range(6, 40);
            for (int k = 0; k < len; k++)
                push_range_sample(next_range(), k == len - 1);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scan_shapes();
        test_register_extremes();
        test_long_scan();
        test_backpressure();
        test_random_scans(RANDOM_ITEMS);
        wait_quiet();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
